// ===== rtl/scrd_pkg.sv =====
// Package for the sum-checked response deframer.
// Holds frame constants, status codes and the result record type.
// No dependencies.
package scrd_pkg;

   localparam logic [7:0]  SYNC_FIRST     = 8'hEF;
   localparam logic [7:0]  SYNC_SECOND    = 8'h01;
   localparam logic [7:0]  ACK_TYPE_RESET = 8'h07;
   localparam int          POS_WIDTH      = 17;
   localparam logic [16:0] POS_MAX        = 17'h1FFFF;
   localparam logic [16:0] POS_SYNC0      = 17'd0;
   localparam logic [16:0] POS_SYNC1      = 17'd1;
   localparam logic [16:0] POS_TYPE       = 17'd6;
   localparam logic [16:0] POS_LEN_HIGH   = 17'd7;
   localparam logic [16:0] POS_LEN_LOW    = 17'd8;
   localparam logic [16:0] POS_BODY       = 17'd9;
   localparam logic [17:0] FRAME_MIN      = 18'd11;
   localparam logic [17:0] HDR_BYTES      = 18'd9;
   localparam logic [16:0] SUM_OFFSET     = 17'd7;
   localparam logic [15:0] LEN_MIN        = 16'd2;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TOO_SHORT = 3'd1,
      ST_BAD_SYNC  = 3'd2,
      ST_NOT_ACK   = 3'd3,
      ST_TRUNCATED = 3'd4,
      ST_BAD_SUM   = 3'd5
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      status_type  status;
      logic [15:0] payload_length;
      logic        last;
   } result_type;

endpackage

// ===== rtl/sum_checked_response_deframer_unit.sv =====
// Response deframer with a 16-bit additive checksum, one byte per transaction.
// Per-frame state registers feed a three-entry result queue.
// Depends on scrd_pkg.
//
//   channel | direction | payload
//   req     | in        | tdata[7:0] rx_byte, tlast end_of_transfer
//   rsp     | out       | tdata payload_byte/frame_status/payload_length, tuser kind, tlast
//   csr     | in        | csr_wr_data ack_type, written when csr_wr_en is high
//
// One byte per cycle while req_tready is high; the byte is checked and summed in
// the cycle it is taken. A byte yields zero, one or two results; the result queue
// holds three, and req_tready is high while it holds at most one, so two-result bytes
// (payload on the final byte) drain at one result per cycle while rsp_tready is high.
// Synchronous reset clears frame state, the queue and sets ack_type to 0x07.
// Results wait in the queue under rsp_tready low; input stalls when it fills.
module sum_checked_response_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] payload_byte, [10:8] frame_status,
                                    // [26:11] payload_length, [31:27] zero
   output logic        rsp_tuser,   // [0] result_kind
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic [7:0]  ack_ff;
   logic [16:0] pos_ff, pos_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  rsumh_ff, rsumh_in;
   logic [15:0] rsum_ff, rsum_in;
   logic        sync_ff, sync_in;
   logic        type_ff, type_in;

   scrd_pkg::result_type q_ff [3];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   logic        accept, pop;
   logic [7:0]  b;
   logic [16:0] sum_at;
   logic        hdr_sum, body, in_payload, emit_payload;
   logic [17:0] count;
   scrd_pkg::status_type status;
   logic [15:0] plen;
   logic [1:0]  npush;
   logic [1:0]  wr_next;
   scrd_pkg::result_type res_pay, res_st, res_first;
   scrd_pkg::result_type head;

   assign accept = req_tvalid & req_tready;
   assign pop    = rsp_tvalid & rsp_tready;
   assign b      = req_tdata;

   always_comb begin
      sum_at     = {1'b0, len_ff} + scrd_pkg::SUM_OFFSET;
      sync_in    = sync_ff;
      type_in    = type_ff;
      len_in     = len_ff;
      if ((pos_ff == scrd_pkg::POS_SYNC0) && (b != scrd_pkg::SYNC_FIRST)) begin
         sync_in = 1'b0;
      end
      if ((pos_ff == scrd_pkg::POS_SYNC1) && (b != scrd_pkg::SYNC_SECOND)) begin
         sync_in = 1'b0;
      end
      if ((pos_ff == scrd_pkg::POS_TYPE) && (b != ack_ff)) begin
         type_in = 1'b0;
      end
      if (pos_ff == scrd_pkg::POS_LEN_HIGH) begin
         len_in = {b, 8'h00};
      end
      if (pos_ff == scrd_pkg::POS_LEN_LOW) begin
         len_in = len_ff | {8'h00, b};
      end

      hdr_sum      = (pos_ff >= scrd_pkg::POS_TYPE) && (pos_ff <= scrd_pkg::POS_LEN_LOW);
      body         = (pos_ff >= scrd_pkg::POS_BODY) && (len_ff >= scrd_pkg::LEN_MIN);
      in_payload   = body && (pos_ff < sum_at);
      emit_payload = in_payload && sync_in && type_in;

      sum_in   = (hdr_sum || in_payload) ? sum_ff + {8'h00, b} : sum_ff;
      rsumh_in = (body && (pos_ff == sum_at)) ? b : rsumh_ff;
      rsum_in  = (body && (pos_ff == sum_at + 17'd1)) ? {rsumh_ff, b} : rsum_ff;

      count = {1'b0, pos_ff} + 18'd1;
      plen  = '0;
      if (count < scrd_pkg::FRAME_MIN) begin
         status = scrd_pkg::ST_TOO_SHORT;
      end else if (!sync_in) begin
         status = scrd_pkg::ST_BAD_SYNC;
      end else if (!type_in) begin
         status = scrd_pkg::ST_NOT_ACK;
      end else if ((len_in < scrd_pkg::LEN_MIN) ||
                   (count < scrd_pkg::HDR_BYTES + {2'b00, len_in})) begin
         status = scrd_pkg::ST_TRUNCATED;
      end else if (sum_in != rsum_in) begin
         status = scrd_pkg::ST_BAD_SUM;
      end else begin
         status = scrd_pkg::ST_OK;
         plen   = len_in - scrd_pkg::LEN_MIN;
      end

      if (req_tlast) begin
         pos_in = '0;
      end else if (pos_ff != scrd_pkg::POS_MAX) begin
         pos_in = pos_ff + 17'd1;
      end else begin
         pos_in = pos_ff;
      end

      res_pay = '{kind: scrd_pkg::KIND_PAYLOAD, payload_byte: b,
                  status: scrd_pkg::ST_OK, payload_length: 16'd0, last: 1'b0};
      res_st  = '{kind: scrd_pkg::KIND_STATUS, payload_byte: 8'd0,
                  status: status, payload_length: plen, last: 1'b1};
      res_first = emit_payload ? res_pay : res_st;
      npush     = accept ? ({1'b0, emit_payload} + {1'b0, req_tlast}) : 2'd0;
   end

   always_comb begin
      wr_next   = (wr_ptr_ff == 2'd2) ? 2'd0 : wr_ptr_ff + 2'd1;
      wr_ptr_in = wr_ptr_ff;
      case (npush)
         2'd1: wr_ptr_in = wr_next;
         2'd2: wr_ptr_in = (wr_next == 2'd2) ? 2'd0 : wr_next + 2'd1;
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == 2'd2) ? 2'd0 : rd_ptr_ff + 2'd1;
      end
      cnt_in = cnt_ff + npush - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_ff    <= scrd_pkg::ACK_TYPE_RESET;
         pos_ff    <= '0;
         len_ff    <= '0;
         sum_ff    <= '0;
         rsumh_ff  <= '0;
         rsum_ff   <= '0;
         sync_ff   <= 1'b1;
         type_ff   <= 1'b1;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            ack_ff <= csr_wr_data;
         end
         if (accept) begin
            if (req_tlast) begin
               pos_ff   <= '0;
               len_ff   <= '0;
               sum_ff   <= '0;
               rsumh_ff <= '0;
               rsum_ff  <= '0;
               sync_ff  <= 1'b1;
               type_ff  <= 1'b1;
            end else begin
               pos_ff   <= pos_in;
               len_ff   <= len_in;
               sum_ff   <= sum_in;
               rsumh_ff <= rsumh_in;
               rsum_ff  <= rsum_in;
               sync_ff  <= sync_in;
               type_ff  <= type_in;
            end
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage, no reset
   always_ff @(posedge clock) begin
      if (npush != 2'd0) begin
         q_ff[wr_ptr_ff] <= res_first;
      end
      if (npush == 2'd2) begin
         q_ff[wr_next] <= res_st;
      end
   end

   assign head       = q_ff[rd_ptr_ff];
   assign req_tready = (cnt_ff <= 2'd1);
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {5'd0, head.payload_length, head.status, head.payload_byte};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd3)
      else $error("result queue overflow");

   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> (pos_ff == '0) && sync_ff && type_ff)
      else $error("frame state not cleared after final byte");

   a_eot_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> cnt_ff != 2'd0)
      else $error("final byte produced no status");

   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == scrd_pkg::KIND_STATUS)
      else $error("tlast on a payload transaction");

endmodule

// ===== dv/testbench.sv =====
// Testbench for sum_checked_response_deframer_unit: streams framed byte transfers,
// predicts payload and status transactions, and checks every result field.
// Depends on scrd_pkg and the deframer RTL.
module testbench;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned PHASE_BYTES = 210;

   class deframe_tracker;
      scrd_pkg::result_type due_results[$];
      logic [7:0]  ack;
      logic [16:0] pos;
      logic [15:0] len;
      logic [15:0] sum;
      logic [7:0]  sum_hi;
      logic [15:0] rx_sum;
      bit          sync_good;
      bit          type_good;
      int unsigned failures;

      function new();
         ack = scrd_pkg::ACK_TYPE_RESET;
         failures = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         pos = '0;
         len = '0;
         sum = '0;
         sum_hi = '0;
         rx_sum = '0;
         sync_good = 1'b1;
         type_good = 1'b1;
      endfunction

      function void set_ack(logic [7:0] value);
         ack = value;
      endfunction

      function int unsigned outstanding();
         return due_results.size();
      endfunction

      function void take_byte(logic [7:0] b, bit eot);
         int unsigned p;
         int unsigned sum_at;
         int unsigned count;
         scrd_pkg::result_type r;
         p = pos;
         sum_at = len + 7;
         if (p == scrd_pkg::POS_SYNC0 && b != scrd_pkg::SYNC_FIRST) sync_good = 1'b0;
         if (p == scrd_pkg::POS_SYNC1 && b != scrd_pkg::SYNC_SECOND) sync_good = 1'b0;
         if (p == scrd_pkg::POS_TYPE && b != ack) type_good = 1'b0;
         if (p == scrd_pkg::POS_LEN_HIGH) len = {b, 8'h00};
         if (p == scrd_pkg::POS_LEN_LOW) len[7:0] = b;
         if (p >= scrd_pkg::POS_TYPE && p <= scrd_pkg::POS_LEN_LOW) begin
            sum = sum + b;
         end else if (p >= scrd_pkg::POS_BODY && len >= scrd_pkg::LEN_MIN) begin
            if (p < sum_at) begin
               sum = sum + b;
               if (sync_good && type_good) begin
                  r = '0;
                  r.kind = scrd_pkg::KIND_PAYLOAD;
                  r.payload_byte = b;
                  due_results.push_back(r);
               end
            end else if (p == sum_at) begin
               sum_hi = b;
            end else if (p == sum_at + 1) begin
               rx_sum = {sum_hi, b};
            end
         end
         if (pos != scrd_pkg::POS_MAX) pos = pos + 1'b1;
         if (eot) begin
            count = p + 1;
            r = '0;
            r.kind = scrd_pkg::KIND_STATUS;
            r.last = 1'b1;
            if (count < scrd_pkg::FRAME_MIN) r.status = scrd_pkg::ST_TOO_SHORT;
            else if (!sync_good) r.status = scrd_pkg::ST_BAD_SYNC;
            else if (!type_good) r.status = scrd_pkg::ST_NOT_ACK;
            else if (len < scrd_pkg::LEN_MIN || count < scrd_pkg::HDR_BYTES + len)
               r.status = scrd_pkg::ST_TRUNCATED;
            else if (sum != rx_sum) r.status = scrd_pkg::ST_BAD_SUM;
            else begin
               r.status = scrd_pkg::ST_OK;
               r.payload_length = len - scrd_pkg::LEN_MIN;
            end
            due_results.push_back(r);
            clear_frame();
         end
      endfunction

      function void check_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            failures++;
            $error("%s: expected %0d, got %0d", name, want, got);
         end
      endfunction

      function void match_result(logic kind, logic [31:0] data, logic tail);
         scrd_pkg::result_type want;
         if (due_results.size() == 0) begin
            failures++;
            $error("result with nothing pending: tuser %0d tdata %h tlast %0d",
                   kind, data, tail);
            return;
         end
         want = due_results.pop_front();
         check_field("result_kind", want.kind, kind);
         check_field("payload_byte", want.payload_byte, data[7:0]);
         check_field("frame_status", want.status, data[10:8]);
         check_field("payload_length", want.payload_length, data[26:11]);
         check_field("tdata_pad", 0, data[31:27]);
         check_field("last", want.last, tail);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] rx_byte
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [7:0] payload_byte, [10:8] frame_status,
                                   // [26:11] payload_length, [31:27] zero
   logic        rsp_tuser;         // [0] result_kind
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   bit          calm = 1'b0;
   bit          hold_request = 1'b0;
   bit          hold_started = 1'b0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;
   logic [7:0]  ack_now = scrd_pkg::ACK_TYPE_RESET;
   logic [7:0]  frame[$];

   deframe_tracker tracker = new();

   sum_checked_response_deframer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** sum_checked_response_deframer_unit: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.match_result(rsp_tuser, rsp_tdata, rsp_tlast);
      if (hold_request && !hold_started) begin
         hold_left <= HOLD_CYCLES;
         hold_started <= 1'b1;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 11);
      end
   end

   function automatic void build_good(int unsigned len, int unsigned extra);
      logic [15:0] s;
      logic [15:0] l;
      l = 16'(len);
      frame = {};
      frame.push_back(scrd_pkg::SYNC_FIRST);
      frame.push_back(scrd_pkg::SYNC_SECOND);
      repeat (4) frame.push_back(8'($urandom_range(255)));
      frame.push_back(ack_now);
      frame.push_back(l[15:8]);
      frame.push_back(l[7:0]);
      for (int unsigned i = 2; i < len; i++) frame.push_back(8'($urandom_range(255)));
      s = '0;
      for (int unsigned i = 6; i < frame.size(); i++) s = s + frame[i];
      frame.push_back(s[15:8]);
      frame.push_back(s[7:0]);
      repeat (extra) frame.push_back(8'($urandom_range(255)));
   endfunction

   function automatic void build_random();
      int unsigned pick;
      int unsigned len;
      int unsigned extra;
      logic [7:0]  flip;
      pick = $urandom_range(99);
      len = ($urandom_range(19) == 0) ? $urandom_range(300, 25) : $urandom_range(24, 2);
      extra = ($urandom_range(9) < 7) ? 0 : $urandom_range(4, 1);
      flip = 8'($urandom_range(255, 1));
      if (pick < 82) build_good(len, extra);
      if (pick >= 55 && pick < 62) begin
         frame[$urandom_range(1)] ^= flip;
      end else if (pick >= 62 && pick < 69) begin
         frame[6] ^= flip;
      end else if (pick >= 69 && pick < 76) begin
         frame[len + 7 + $urandom_range(1)] ^= flip;
      end else if (pick >= 76 && pick < 82) begin
         frame = frame[0 : $urandom_range(frame.size() - 2)];
      end else if (pick >= 82 && pick < 88) begin
         build_good($urandom_range(1), $urandom_range(10, 2));
      end else if (pick >= 88) begin
         frame = {};
         repeat ($urandom_range(pick < 94 ? 10 : 30, 1))
            frame.push_back(8'($urandom_range(255)));
         if (frame.size() >= 2 && $urandom_range(1)) begin
            frame[0] = scrd_pkg::SYNC_FIRST;
            frame[1] = scrd_pkg::SYNC_SECOND;
         end
      end
   endfunction

   task automatic send_frame();
      for (int unsigned i = 0; i < frame.size(); i++) begin
         if (!calm && $urandom_range(99) < 11) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= frame[i];
         req_tlast <= (i == frame.size() - 1);
         do @(posedge clock); while (!req_tready);
         tracker.take_byte(frame[i], i == frame.size() - 1);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_ack(logic [7:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      tracker.set_ack(value);
      ack_now = value;
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int unsigned sent;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      frame = {8'hFF};
      send_frame();
      build_good(2, 0);
      send_frame();
      build_good(4, 0);
      frame[9] = 8'h00;
      frame[10] = 8'hFF;
      frame = frame[0:10];
      send_frame();
      build_good(4, 0);
      frame[7] = 8'hFF;
      frame[8] = 8'hFF;
      send_frame();

      for (int phase = 0; phase < 6; phase++) begin
         if (phase != 0) begin
            drain();
            case (phase)
               1: write_ack(8'h00);
               2: write_ack(8'hFF);
               5: write_ack(scrd_pkg::ACK_TYPE_RESET);
               default: write_ack(8'($urandom_range(255)));
            endcase
         end
         calm <= (phase == 2);
         if (phase == 1) hold_request <= 1'b1;
         sent = 0;
         while (sent < PHASE_BYTES) begin
            build_random();
            send_frame();
            sent += frame.size();
         end
      end

      calm <= 1'b0;
      drain();
      repeat (8) @(posedge clock);
      if (tracker.failures == 0 && tracker.outstanding() == 0) begin
         $display("** sum_checked_response_deframer_unit: PASSED **");
      end else begin
         $display("** sum_checked_response_deframer_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sum_checked_response_deframer_unit.f =====
rtl/scrd_pkg.sv
rtl/sum_checked_response_deframer_unit.sv
dv/testbench.sv
